[sv/sve_pkg.sv]
// ----------------------------------------------------------------------------
// sve_pkg
// Shared types and constants for the signed varint encoder: group layout,
// controller state encoding and the command/status bundles.
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int GROUP_BITS     = 7;
  localparam int BYTE_BITS      = 8;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } sve_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new value
    logic shift;  // move to the next group
    logic emit;   // write the top group to the output register
    logic fin;    // this group is the final one of the item
  } sve_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_drop;   // top group is redundant sign extension
    logic slot_free;  // output register can take a byte this cycle
  } sve_sts_t;

endpackage

[sv/sve_if.sv]
// ----------------------------------------------------------------------------
// sve_in_if / sve_out_if
// Valid/ready channels for the encoder: value in, encoded bytes out.
// ----------------------------------------------------------------------------
interface sve_in_if #(
  parameter int VALUE_BITS = sve_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sve_out_if;
  logic                           valid;
  logic                           ready;
  logic [sve_pkg::BYTE_BITS-1:0]  out_byte;
  logic                           last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[sv/sve_ctrl.sv]
// ----------------------------------------------------------------------------
// sve_ctrl
// Sequencer for the encoder: walks one value's groups top down, drops leading
// sign-extension groups, then emits the rest a byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module sve_ctrl #(
  parameter int VALUE_BITS = sve_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sve_pkg::sve_sts_t sts,
  output sve_pkg::sve_cmd_t cmd
);
  import sve_pkg::*;

  localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

  sve_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lead_r, lead_nxt;

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        if (lead_r && (cnt_r > CNT_W'(1)) && sts.can_drop) begin
          cmd.shift = 1'b1;
        end else if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          cmd.fin   = (cnt_r == CNT_W'(1));
          // take the next item while the final byte goes out
          if (cnt_r == CNT_W'(1)) begin
            in_ready = 1'b1;
            cmd.load = in_valid;
          end
        end
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lead_nxt  = lead_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          cnt_nxt   = CNT_W'(MAX_GROUPS);
          lead_nxt  = 1'b1;
        end
      end
      ST_RUN: begin
        if (cmd.shift) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        if (cmd.emit) begin
          lead_nxt = 1'b0;
        end
        if (cmd.fin) begin
          if (in_valid) begin
            cnt_nxt  = CNT_W'(MAX_GROUPS);
            lead_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      lead_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lead_r  <= lead_nxt;
    end
  end

endmodule

[sv/sve_dp.sv]
// ----------------------------------------------------------------------------
// sve_dp
// Datapath: sign-extended value shift register, group-trim check and the
// registered output byte.
// ----------------------------------------------------------------------------
module sve_dp #(
  parameter int VALUE_BITS = sve_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  sve_pkg::sve_cmd_t            cmd,
  output sve_pkg::sve_sts_t            sts,
  sve_out_if.source                    out_chan
);
  import sve_pkg::*;

  localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int EXT_BITS   = MAX_GROUPS * GROUP_BITS;

  logic signed [EXT_BITS-1:0]  ext_value;
  logic [EXT_BITS-1:0]         val_r;
  logic [BYTE_BITS-1:0]        out_byte_r;
  logic                        last_r;
  logic                        out_valid_r;
  logic [GROUP_BITS:0]         top_bits;

  assign ext_value = EXT_BITS'(in_value);

  // top group plus bit 6 of the next group all equal: top group is redundant
  assign top_bits      = val_r[EXT_BITS-1 -: (GROUP_BITS + 1)];
  assign sts.can_drop  = (top_bits == '0) || (top_bits == '1);
  assign sts.slot_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= ext_value;
    end else if (cmd.shift) begin
      val_r <= val_r << GROUP_BITS;
    end
    if (cmd.emit) begin
      out_byte_r <= {~cmd.fin, val_r[EXT_BITS-1 -: GROUP_BITS]};
      last_r     <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = last_r;

endmodule

[sv/signed_varint_encoder.sv]
// ----------------------------------------------------------------------------
// signed_varint_encoder
// Flow: after an item is taken the sequencer skips leading sign-extension
//   groups, then emits one byte per remaining group; the next item is taken
//   while the final byte goes out. The group sequencer steps one group per
//   cycle, except that an output stall holds it on a byte to be emitted.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module signed_varint_encoder #(
  parameter int VALUE_BITS = sve_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sve_in_if.sink    in_chan,
  sve_out_if.source out_chan
);
  import sve_pkg::*;

  sve_cmd_t cmd;
  sve_sts_t sts;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  sve_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sve_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_chan.value),
    .cmd      (cmd),
    .sts      (sts),
    .out_chan (out_chan)
  );

endmodule
